### rtl/core/npl_pkg.sv
`default_nettype none

package npl_pkg;

   // Field widths of the request and response words
   localparam int OPCODE_W  = 1;
   localparam int INDEX_W   = 10;
   localparam int ADDR_W    = 32;
   localparam int COUNT_W   = 11;

   // Packed word widths, padded to whole bytes
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 48;

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### rtl/core/nearest_predecessor_lookup.sv
`default_nettype none

// Nearest predecessor lookup. A table of TABLE_DEPTH 32-bit symbol start
// addresses sits in one synchronous RAM. A write word (tuser = 0) stores
// an address at a slot; slots at or above TABLE_DEPTH are
// dropped, and writes produce no response. A query word (tuser = 1) scans
// slots 0 .. min(entry_count, TABLE_DEPTH)-1, one RAM read per cycle, and
// returns the slot whose address is the greatest one not above the query
// address (ties go to the later slot), with the offset from it and an
// exact-hit flag; when nothing qualifies all response fields are zero.
// A query holds off further request words until its response is loaded
// into the output register; the scan is paced by the single RAM read port.
// The response sits in an output register, so the next word is taken while
// a finished response still waits. Write entry_count only while idle.
// Slots must be written before any query scans them.
module nearest_predecessor_lookup #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // csr: entry_count
   input  wire logic                          csr_we,
   input  wire logic [npl_pkg::COUNT_W-1:0]   csr_wdata,
   // request channel
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   // [9:0] entry_index, [41:10] entry_address, [73:42] query_address
   input  wire logic [npl_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] opcode
   input  wire logic                          req_tuser,
   // response channel
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [0] found, [10:1] match_index, [42:11] offset, [43] exact_hit
   output      logic [npl_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int LW    = (CNT_W > npl_pkg::COUNT_W) ? CNT_W : npl_pkg::COUNT_W;
   localparam int XW    = (CNT_W > npl_pkg::INDEX_W) ? CNT_W : npl_pkg::INDEX_W;

   // Unpack the request word
   logic [npl_pkg::INDEX_W-1:0] req_entry_index;
   logic [npl_pkg::ADDR_W-1:0]  req_entry_address;
   logic [npl_pkg::ADDR_W-1:0]  req_query_address;
   logic                        req_accept;

   assign req_entry_index   = req_tdata[npl_pkg::INDEX_W-1:0];
   assign req_entry_address = req_tdata[npl_pkg::INDEX_W +: npl_pkg::ADDR_W];
   assign req_query_address = req_tdata[npl_pkg::INDEX_W + npl_pkg::ADDR_W +: npl_pkg::ADDR_W];
   assign req_accept        = req_tvalid & req_tready;

   // State
   npl_pkg::state_type state_ff, state_in;

   logic [npl_pkg::COUNT_W-1:0] count_ff;
   logic [npl_pkg::ADDR_W-1:0]  qaddr_ff, qaddr_in;
   logic [CNT_W-1:0]            limit_ff, limit_in;
   logic [CNT_W-1:0]            rd_cnt_ff, rd_cnt_in;
   logic                        cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]               cmp_idx_ff, cmp_idx_in;
   logic [npl_pkg::ADDR_W-1:0]  rd_data_ff;
   logic                        hit_ff, hit_in;
   logic [AW-1:0]               best_idx_ff, best_idx_in;
   logic [npl_pkg::ADDR_W-1:0]  best_dist_ff, best_dist_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [npl_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [npl_pkg::ADDR_W-1:0]  table_mem [TABLE_DEPTH];

   // Control strobes
   logic issue;
   logic scan_end;
   logic load_rsp;
   logic mem_we;
   logic start_query;

   // Scan limit is entry_count clipped to the table depth
   logic [LW-1:0] count_ext;
   logic [LW-1:0] depth_ext;

   assign count_ext = LW'(count_ff);
   assign depth_ext = LW'(TABLE_DEPTH);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         npl_pkg::ST_IDLE: begin
            if (start_query) begin
               state_in = npl_pkg::ST_SCAN;
            end
         end
         npl_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = npl_pkg::ST_DONE;
            end
         end
         npl_pkg::ST_DONE: begin
            if (load_rsp) begin
               state_in = npl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npl_pkg::ST_IDLE;
         end
      endcase
   end

   // Control outputs
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      scan_end   = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         npl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         npl_pkg::ST_SCAN: begin
            issue    = (rd_cnt_ff < limit_ff);
            scan_end = (rd_cnt_ff >= limit_ff) && !cmp_vld_ff;
         end
         npl_pkg::ST_DONE: begin
            load_rsp = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign start_query = req_accept && (req_tuser == npl_pkg::OP_QUERY);
   assign mem_we      = req_accept && (req_tuser == npl_pkg::OP_WRITE) &&
                        (XW'(req_entry_index) < XW'(TABLE_DEPTH));

   // Compare the word read last cycle against the best so far
   logic                       cmp_ge;
   logic [npl_pkg::ADDR_W-1:0] cmp_dist;
   logic                       take;

   assign cmp_ge   = (qaddr_ff >= rd_data_ff);
   assign cmp_dist = qaddr_ff - rd_data_ff;
   assign take     = cmp_vld_ff && cmp_ge && (!hit_ff || (cmp_dist <= best_dist_ff));

   // Datapath next values
   always_comb begin
      qaddr_in     = qaddr_ff;
      limit_in     = limit_ff;
      rd_cnt_in    = rd_cnt_ff;
      cmp_vld_in   = issue;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (start_query) begin
         qaddr_in     = req_query_address;
         limit_in     = (count_ext > depth_ext) ? CNT_W'(depth_ext) : CNT_W'(count_ext);
         rd_cnt_in    = '0;
         hit_in       = 1'b0;
         best_idx_in  = '0;
         best_dist_in = '0;
      end

      // Advance the read pointer
      if (issue) begin
         rd_cnt_in  = rd_cnt_ff + CNT_W'(1);
         cmp_idx_in = rd_cnt_ff[AW-1:0];
      end

      // Keep the later of equal distances
      if (take) begin
         hit_in       = 1'b1;
         best_idx_in  = cmp_idx_ff;
         best_dist_in = cmp_dist;
      end

      // Hold the response until taken
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000,
                         hit_ff && (best_dist_ff == '0),
                         best_dist_ff,
                         npl_pkg::INDEX_W'(best_idx_ff),
                         hit_ff};
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npl_pkg::ST_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      qaddr_ff     <= qaddr_in;
      limit_ff     <= limit_in;
      rd_cnt_ff    <= rd_cnt_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_ff       <= hit_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Address table: writes only while idle, so reads never overlap them
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[AW'(req_entry_index)] <= req_entry_address;
      end
      if (issue) begin
         rd_data_ff <= table_mem[rd_cnt_ff[AW-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
